/* rtl/core/dq_pkg.sv */
// ----------------------------------------------------------------------------
// dq_pkg
// Shared types and codes for the double-ended queue: operation codes, result
// status codes, field widths and the result beat handed from the sequencer to
// the output stage.
// ----------------------------------------------------------------------------
package dq_pkg;

  // Field widths fixed by the stream format
  localparam int DATA_W   = 32;
  localparam int MODE_W   = 3;
  localparam int STATUS_W = 2;

  // Operation codes carried on in_tuser
  localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
  localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_DUMP       = 3'd4;

  // Result status codes carried on out_tuser
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // One result beat, less the occupancy (its width follows the depth)
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   data;
    logic                last;
  } dq_res_t;

endpackage

/* rtl/core/double_ended_queue.sv */
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded double-ended queue of signed 32-bit values held in a ring store.
// ----------------------------------------------------------------------------
// Each input beat carries one operation on in_tuser (push front, push back,
// pop front, pop back, dump) and a push value on in_tdata. A push, an unused
// code and a pop or dump of an empty queue finish in the accept cycle. A pop
// of a held entry waits for one read of the entry store. A dump streams one
// beat per entry from the store's read port, front to back, tlast on the final
// one. Every other operation returns exactly one beat with tlast set; unused
// codes return none. A refused push reports full, a pop or dump of an empty
// queue reports empty. A result register sits on the output; while it holds a
// beat that out_tready has not taken, in_tready is low and the sequencer
// waits. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module double_ended_queue import dq_pkg::*; #(
  parameter int DEPTH = 16,
  localparam int IDX_W = $clog2(DEPTH),
  localparam int CNT_W = $clog2(DEPTH + 1),
  localparam int OUT_W = ((DATA_W + CNT_W + 7) / 8) * 8
) (
  input  logic                clk,
  input  logic                rst_n,
  // operation stream
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [DATA_W-1:0]   in_tdata,   // [31:0] value
  input  logic [MODE_W-1:0]   in_tuser,   // [2:0] mode
  // result stream
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [OUT_W-1:0]    out_tdata,  // [31:0] data, then occupancy, zero pad
  output logic [STATUS_W-1:0] out_tuser,  // [1:0] status
  output logic                out_tlast
);

  logic              ram_we, ram_re;
  logic [IDX_W-1:0]  ram_waddr, ram_raddr;
  logic [DATA_W-1:0] ram_wdata, ram_rdata;

  logic              res_ready, res_valid;
  dq_res_t           res;
  logic [CNT_W-1:0]  res_occ;

  logic              out_valid_r;
  dq_res_t           out_res_r;
  logic [CNT_W-1:0]  out_occ_r;

  dq_ram #(.DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  dq_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_mode   (in_tuser),
    .in_value  (in_tdata),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .res_ready (res_ready),
    .res_valid (res_valid),
    .res       (res),
    .res_occ   (res_occ)
  );

  // Output register: takes a new beat when empty or draining
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_res_r <= res;
      out_occ_r <= res_occ;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'({out_occ_r, out_res_r.data});
  assign out_tuser  = out_res_r.status;
  assign out_tlast  = out_res_r.last;

endmodule

/* rtl/core/dq_ram.sv */
// ----------------------------------------------------------------------------
// dq_ram
// Entry store: one write port, one read port, registered read data. The read
// data register only loads on a read, so it holds while the consumer stalls.
// ----------------------------------------------------------------------------
module dq_ram import dq_pkg::*; #(
  parameter int DEPTH = 16,
  localparam int IDX_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [IDX_W-1:0]  waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [IDX_W-1:0]  raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/core/dq_ctrl.sv */
// ----------------------------------------------------------------------------
// dq_ctrl
// Queue sequencer: keeps the front index and entry count, decodes each
// operation, drives the entry store and builds the result beats. Pushes
// finish in the accept cycle, pops wait for the registered store read, a
// dump walks the held range one entry per cycle while res_ready is high.
// ----------------------------------------------------------------------------
module dq_ctrl import dq_pkg::*; #(
  parameter int DEPTH = 16,
  localparam int IDX_W = $clog2(DEPTH),
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  // operation request
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [MODE_W-1:0] in_mode,
  input  logic [DATA_W-1:0] in_value,
  // entry store
  output logic              ram_we,
  output logic [IDX_W-1:0]  ram_waddr,
  output logic [DATA_W-1:0] ram_wdata,
  output logic              ram_re,
  output logic [IDX_W-1:0]  ram_raddr,
  input  logic [DATA_W-1:0] ram_rdata,
  // result beat
  input  logic              res_ready,
  output logic              res_valid,
  output dq_res_t           res,
  output logic [CNT_W-1:0]  res_occ
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_POP  = 2'd1;
  localparam logic [1:0] S_DUMP = 2'd2;

  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);

  logic [1:0]       state_r, state_nxt;
  logic [IDX_W-1:0] front_r, front_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;

  logic             accept;
  logic             is_full, is_empty;
  logic [CNT_W-1:0] count_m1;
  logic [IDX_W-1:0] front_dec, front_inc, idx_inc;
  logic             dump_last;

  // (base + off) mod DEPTH, both operands below DEPTH
  function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                                input logic [IDX_W-1:0] off);
    logic [IDX_W:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (IDX_W+1)'(DEPTH)) begin
      sum = sum - (IDX_W+1)'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  assign in_ready  = (state_r == S_IDLE) && res_ready;
  assign accept    = in_valid && in_ready;
  assign is_full   = (count_r == CNT_FULL);
  assign is_empty  = (count_r == '0);
  assign count_m1  = count_r - CNT_W'(1);
  assign front_dec = (front_r == '0) ? IDX_LAST : front_r - IDX_W'(1);
  assign front_inc = (front_r == IDX_LAST) ? '0 : front_r + IDX_W'(1);
  assign idx_inc   = idx_r + IDX_W'(1);
  assign dump_last = (CNT_W'(idx_r) + CNT_W'(1)) == count_r;

  // Operation decode and sequencing
  always_comb begin
    state_nxt  = state_r;
    front_nxt  = front_r;
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    ram_we     = 1'b0;
    ram_waddr  = front_r;
    ram_wdata  = in_value;
    ram_re     = 1'b0;
    ram_raddr  = front_r;
    res_valid  = 1'b0;
    res.status = ST_OK;
    res.data   = '0;
    res.last   = 1'b1;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_mode)
            MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
              res_valid = 1'b1;
              if (is_full) begin
                res.status = ST_FULL;
              end else begin
                ram_we    = 1'b1;
                count_nxt = count_r + CNT_W'(1);
                if (in_mode == MODE_PUSH_FRONT) begin
                  front_nxt = front_dec;
                  ram_waddr = front_dec;
                end else begin
                  ram_waddr = ring_add(front_r, IDX_W'(count_r));
                end
              end
            end
            MODE_POP_FRONT, MODE_POP_BACK: begin
              if (is_empty) begin
                res_valid  = 1'b1;
                res.status = ST_EMPTY;
              end else begin
                ram_re    = 1'b1;
                count_nxt = count_m1;
                state_nxt = S_POP;
                if (in_mode == MODE_POP_FRONT) begin
                  front_nxt = front_inc;
                end else begin
                  ram_raddr = ring_add(front_r, IDX_W'(count_m1));
                end
              end
            end
            MODE_DUMP: begin
              if (is_empty) begin
                res_valid  = 1'b1;
                res.status = ST_EMPTY;
              end else begin
                ram_re    = 1'b1;
                idx_nxt   = '0;
                state_nxt = S_DUMP;
              end
            end
            default: begin
              // unused codes: consumed, no effect
            end
          endcase
        end
      end
      S_POP: begin
        if (res_ready) begin
          res_valid = 1'b1;
          res.data  = ram_rdata;
          state_nxt = S_IDLE;
        end
      end
      S_DUMP: begin
        // store output holds entry idx_r; fetch the next one as it leaves
        if (res_ready) begin
          res_valid = 1'b1;
          res.data  = ram_rdata;
          res.last  = dump_last;
          if (dump_last) begin
            state_nxt = S_IDLE;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = ring_add(front_r, idx_inc);
            idx_nxt   = idx_inc;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign res_occ = count_nxt;

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      front_r <= '0;
      count_r <= '0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      front_r <= front_nxt;
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL)
    else $error("entry count above depth");

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("store read and write in the same cycle");

  a_res_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> res_ready)
    else $error("result beat issued with output stage full");

  a_dump_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DUMP) |-> (CNT_W'(idx_r) < count_r))
    else $error("dump index outside held range");

  a_pop_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_POP) && res_ready |=> (state_r == S_IDLE))
    else $error("pop result not retired");

endmodule
